// ----- rtl/core/rcl_pkg.sv -----
// ----------------------------------------------------------------------------
// rcl_pkg
// Types and constants shared by the per-client rate limiter modules.
// ----------------------------------------------------------------------------
package rcl_pkg;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		REG_ENABLE = 2'd0,
		REG_RATE   = 2'd1,
		REG_BURST  = 2'd2,
		REG_WINDOW = 2'd3
	} reg_idx_t;

	typedef enum logic {
		REQ_CHECK = 1'b0,
		REQ_CLEAR = 1'b1
	} req_kind_t;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  client_id;
		logic [31:0] time_now;
	} req_t;

	typedef struct packed {
		logic        allowed;
		logic        used_burst;
		logic [31:0] denied_count;
	} rsp_t;

	typedef struct packed {
		logic        limit_enable;
		logic [15:0] requests_per_window;
		logic [15:0] burst_allowance;
		logic [31:0] window_ticks;
	} cfg_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] win_begin;
		logic [16:0] win_count;
		logic [15:0] tokens;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

	localparam cfg_t CFG_RESET = '{
		limit_enable:        1'b1,
		requests_per_window: 16'd100,
		burst_allowance:     16'd10,
		window_ticks:        32'd1000
	};

endpackage

// ----- rtl/core/rcl_ram.sv -----
// ----------------------------------------------------------------------------
// rcl_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module rcl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/core/rcl_regs.sv -----
// ----------------------------------------------------------------------------
// rcl_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module rcl_regs
	import rcl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	reg_idx_t idx;
	logic     wr;
	cfg_t     cfg_q;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr) begin
			case (idx)
				REG_ENABLE: cfg_q.limit_enable        <= pwdata[0];
				REG_RATE:   cfg_q.requests_per_window <= pwdata[15:0];
				REG_BURST:  cfg_q.burst_allowance     <= pwdata[15:0];
				REG_WINDOW: cfg_q.window_ticks        <= pwdata;
				default:    cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ENABLE: prdata = {31'd0, cfg_q.limit_enable};
			REG_RATE:   prdata = {16'd0, cfg_q.requests_per_window};
			REG_BURST:  prdata = {16'd0, cfg_q.burst_allowance};
			REG_WINDOW: prdata = cfg_q.window_ticks;
			default:    prdata = '0;
		endcase
	end

endmodule

// ----- rtl/core/rcl_engine.sv -----
// ----------------------------------------------------------------------------
// rcl_engine
// Client table read-modify-write pipeline with forwarding and clearing pass.
// ----------------------------------------------------------------------------
module rcl_engine
	import rcl_pkg::*;
#(
	parameter int CLIENTS = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	localparam int IDX_W = $clog2(CLIENTS);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CLIENTS - 1);

	logic                 accept;
	logic [IDX_W+7:0]     id_ext;
	logic [IDX_W-1:0]     idx;
	logic                 in_range;

	logic                 clr_active_q;
	logic [IDX_W-1:0]     clr_cnt_q;

	logic                 vld_s1;
	req_t                 req_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic                 inrng_s1;
	logic                 fwd_hit_s1;
	entry_t               fwd_data_s1;

	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	entry_t               wr_data;
	logic [ENTRY_W-1:0]   rd_raw;

	entry_t               ent;
	entry_t               new_ent;
	logic [31:0]          elapsed;
	logic                 restart;
	logic [16:0]          base_count;
	logic [15:0]          base_tok;
	logic [16:0]          cnt_inc;
	logic                 wr_req;
	logic                 allowed;
	logic                 burst;
	logic                 deny;

	logic [31:0]          denied_q;
	logic                 done_q;
	rsp_t                 rsp_q;

	assign busy     = clr_active_q;
	assign accept   = start & ~busy;
	assign id_ext   = {{IDX_W{1'b0}}, req.client_id};
	assign idx      = id_ext[IDX_W-1:0];
	assign in_range = {24'd0, req.client_id} < 32'(CLIENTS);

	// clearing pass after reset and after each clear beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_cnt_q    <= '0;
		end else if (accept && req.req_type == REQ_CLEAR) begin
			clr_active_q <= 1'b1;
			clr_cnt_q    <= '0;
		end else if (clr_active_q) begin
			if (clr_cnt_q == IDX_LAST) begin
				clr_active_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	assign wr_en   = clr_active_q | wr_req;
	assign wr_addr = clr_active_q ? clr_cnt_q : idx_s1;
	assign wr_data = clr_active_q ? entry_t'('0) : new_ent;

	rcl_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CLIENTS)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (accept),
		.rd_addr (idx),
		.rd_data (rd_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1      <= req;
			idx_s1      <= idx;
			inrng_s1    <= in_range;
			fwd_hit_s1  <= wr_en && (wr_addr == idx);
			fwd_data_s1 <= wr_data;
		end
	end

	// window check and update
	always_comb begin
		ent        = fwd_hit_s1 ? fwd_data_s1 : entry_t'(rd_raw);
		elapsed    = req_s1.time_now - ent.win_begin;
		restart    = !ent.valid || (elapsed >= cfg.window_ticks);
		base_count = restart ? 17'd0 : ent.win_count;
		base_tok   = restart ? cfg.burst_allowance : ent.tokens;
		cnt_inc    = (base_count == COUNT_MAX) ? base_count : base_count + 17'd1;
		wr_req     = vld_s1 && (req_s1.req_type == REQ_CHECK) && cfg.limit_enable
			&& inrng_s1;

		new_ent.valid     = 1'b1;
		new_ent.win_begin = restart ? req_s1.time_now : ent.win_begin;
		new_ent.win_count = cnt_inc;
		new_ent.tokens    = base_tok;
		allowed           = 1'b1;
		burst             = 1'b0;
		deny              = 1'b0;

		if (base_count >= {1'b0, cfg.requests_per_window}) begin
			if (base_tok != 16'd0) begin
				new_ent.tokens = base_tok - 16'd1;
				burst          = 1'b1;
			end else begin
				new_ent.win_count = base_count;
				allowed           = 1'b0;
				deny              = 1'b1;
			end
		end

		if (!wr_req) begin
			allowed = 1'b1;
			burst   = 1'b0;
			deny    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			denied_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= vld_s1;
			if (vld_s1 && deny) begin
				denied_q <= denied_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			rsp_q.allowed      <= allowed;
			rsp_q.used_burst   <= burst;
			rsp_q.denied_count <= denied_q + {31'd0, deny};
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ----- rtl/core/per_client_rate_limiter_top.sv -----
// ----------------------------------------------------------------------------
// per_client_rate_limiter_top
// Per-client fixed-window rate limiter with burst tokens and APB config.
// ----------------------------------------------------------------------------
// result strobe on done follows the stage-1 register and the done register, always one result
// throughput: one request check per cycle while busy is low, set by one table read-modify-write
// a clear beat is followed by a table sweep over all CLIENTS entries with busy high
// after reset busy stays high for the same sweep over all CLIENTS entries
// the receiver cannot stall; every result is shown for exactly one cycle
module per_client_rate_limiter_top
	import rcl_pkg::*;
#(
	parameter int CLIENTS = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  req_t              req,
	output logic              done,
	output rsp_t              rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t cfg;

	rcl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rcl_engine #(
		.CLIENTS (CLIENTS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

// ----- rtl/core/rcl_checker.sv -----
// ----------------------------------------------------------------------------
// rcl_checker
// Port-level checks on the rate limiter, bound to the top level.
// ----------------------------------------------------------------------------
module rcl_checker
	import rcl_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input req_t req,
	input logic done,
	input rsp_t rsp
);

	// every accepted beat gives its result strobe on done
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("accepted beat without result");

	// a clear beat starts the table sweep
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.req_type == REQ_CLEAR |=> busy)
		else $error("clear beat without sweep");

	a_burst_allowed: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.used_burst |-> rsp.allowed)
		else $error("burst token spent on denied request");

	a_deny_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(done) && !rsp.allowed |->
		rsp.denied_count == $past(rsp.denied_count) + 32'd1)
		else $error("denied total not stepped by one");

	a_allow_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(done) && rsp.allowed |->
		rsp.denied_count == $past(rsp.denied_count))
		else $error("denied total moved on allowed beat");

endmodule

bind per_client_rate_limiter_top rcl_checker u_checker (.*);
